/* hw/rtl/tpcw_pkg.sv */
// Package for the track position coincidence window.
// Holds the sizes, register indexes, request and result types and the
// sequencer state codes. Depends on nothing.
package tpcw_pkg;

  // Sizes of the window and of the coordinates.
  localparam int CAMERAS        = 2;
  localparam int TRACKS         = 15;
  localparam int LOOKBACK_DEPTH = 8;
  localparam int COORD_BITS     = 16;
  localparam int SLOTS          = LOOKBACK_DEPTH + 1;
  localparam int MAX_RESULTS    = 64;

  // Derived widths.
  localparam int CamW    = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
  localparam int SlotW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FillW   = $clog2(LOOKBACK_DEPTH + 2);
  localparam int TrkW    = $clog2(TRACKS + 1);
  localparam int PsW     = (SLOTS * CAMERAS > 1) ? $clog2(SLOTS * CAMERAS) : 1;
  localparam int MemAW   = $clog2(SLOTS * CAMERAS * TRACKS);
  localparam int CmpW    = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int ResCntW = $clog2(MAX_RESULTS + 1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_METHOD    = 2'd1;
  localparam logic [1:0] CFG_LOOKBACK  = 2'd2;

  // Distance test codes.
  localparam logic [1:0] METHOD_SQUARE = 2'd0;
  localparam logic [1:0] METHOD_CIRCLE = 2'd1;
  localparam logic [1:0] METHOD_CROSS  = 2'd2;

  typedef struct packed {
    logic        camera;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic        has_track;
    logic        end_of_event;
  } tpcw_in_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] this_event;
    logic [3:0]  this_track;
    logic [31:0] matched_event;
    logic [3:0]  matched_track;
    logic        last_result;
  } tpcw_res_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SETUP  = 9'b000000010,
    ST_SLOT   = 9'b000000100,
    ST_READ   = 9'b000001000,
    ST_DIFF   = 9'b000010000,
    ST_SQX    = 9'b000100000,
    ST_SQY    = 9'b001000000,
    ST_TEST   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } tpcw_state_e;

endpackage

/* hw/rtl/track_position_coincidence_window_top.sv */
// Top level of the track position coincidence window.
// Holds the walk sequencer, the shared multiplier and the position memory.
// Depends on tpcw_pkg.

// A request is taken when start_i is high and busy_o is low. A request that
// carries a usable track walks every stored position of its camera in the
// earlier events held, oldest event first, one position at a time through a
// single shared difference, multiply and compare unit. Each position passes
// through memory read, difference and test with the square and cross tests;
// the circle test squares the x and then the y difference before the test.
// Results appear on res_o for one cycle each with res_strobe_o high and
// cannot be held off; the last result of a request carries last_result. A
// request without a usable track gives no result and busy_o stays low.
// Configuration writes are always ready.
module track_position_coincidence_window_top
  import tpcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  tpcw_in_t   req_i,
  output logic       busy_o,
  output logic       res_strobe_o,
  output tpcw_res_t  res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int MulW = 2 * CmpW;

  tpcw_state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] thresh_q, thresh_d;
  logic [1:0]  method_q, method_d;
  logic [3:0]  lookback_q, lookback_d;

  // Window state.
  logic [TrkW-1:0]  tps_q [SLOTS*CAMERAS];
  logic [TrkW-1:0]  tps_d [SLOTS*CAMERAS];
  logic [TrkW-1:0]  cur_trk_q [CAMERAS];
  logic [TrkW-1:0]  cur_trk_d [CAMERAS];
  logic [31:0]      event_q, event_d;
  logic [SlotW-1:0] oldest_q, oldest_d;
  logic [FillW-1:0] filled_q, filled_d;

  // Request and walk registers.
  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [CamW-1:0]       cam_q, cam_d;
  logic                  eoe_q, eoe_d;
  logic [TrkW-1:0]       v_q, v_d;
  logic [FillW-1:0]      i_q, i_d;
  logic [SlotW-1:0]      s_q, s_d;
  logic [TrkW-1:0]       z_q, z_d;
  logic [TrkW-1:0]       cnt_q, cnt_d;
  logic [COORD_BITS-1:0] xd_q, xd_d, yd_q, yd_d;
  logic                  orig_q, orig_d;
  logic [MulW-1:0]       th2_q, th2_d;
  logic [MulW:0]         acc_q, acc_d;
  logic [ResCntW-1:0]    n_q, n_d;
  tpcw_res_t             pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  tpcw_res_t             res_q, res_d;
  logic                  strobe_q, strobe_d;

  // Position memory, packed as y above x.
  logic [2*COORD_BITS-1:0] mem [SLOTS*CAMERAS*TRACKS];
  logic [2*COORD_BITS-1:0] rdata_q;
  logic                    rd_en, wr_en;
  logic [MemAW-1:0]        rd_addr, wr_addr;
  logic [2*COORD_BITS-1:0] wr_data;

  // Shared multiplier.
  logic [CmpW-1:0] mul_a, mul_b;
  logic [MulW-1:0] mul_p;

  // Helpers.
  logic [CamW-1:0]       in_cam;
  logic                  track_ok;
  logic [SlotW:0]        cur_sum;
  logic [SlotW-1:0]      cur_slot;
  logic [PsW-1:0]        walk_ps;
  logic [PsW-1:0]        cur_ps;
  logic [TrkW-1:0]       slot_cnt;
  logic [COORD_BITS-1:0] px, py;
  logic [CmpW-1:0]       th_w, xd_w, yd_w;
  logic                  dist_ok;
  logic                  do_eoe;
  logic [FillW:0]        fill_inc;
  logic [FillW:0]        window;
  logic [SlotW-1:0]      s_next;

  assign in_cam   = CamW'(req_i.camera);
  assign track_ok = req_i.has_track && (int'(req_i.camera) < CAMERAS)
                    && (cur_trk_q[in_cam] < TrkW'(TRACKS));

  // Slot in which the current event is built.
  assign cur_sum  = {1'b0, oldest_q} + (SlotW+1)'(filled_q);
  assign cur_slot = (cur_sum >= (SlotW+1)'(SLOTS)) ? SlotW'(cur_sum - (SlotW+1)'(SLOTS))
                                                   : SlotW'(cur_sum);
  assign walk_ps  = PsW'(s_q * CAMERAS + cam_q);
  assign cur_ps   = PsW'(cur_slot * CAMERAS + cam_q);
  assign slot_cnt = (tps_q[walk_ps] > TrkW'(TRACKS)) ? TrkW'(TRACKS) : tps_q[walk_ps];
  assign s_next   = (s_q == SlotW'(SLOTS - 1)) ? '0 : s_q + 1'b1;

  assign rd_addr = MemAW'(walk_ps * TRACKS + z_q);
  assign wr_addr = MemAW'(cur_ps * TRACKS + v_q);
  assign wr_data = {y_q, x_q};

  assign px = rdata_q[COORD_BITS-1:0];
  assign py = rdata_q[2*COORD_BITS-1:COORD_BITS];

  // Multiplier operands follow the sequencer step.
  always_comb begin
    unique case (state_q)
      ST_SQX:  begin mul_a = CmpW'(xd_q);  mul_b = CmpW'(xd_q);  end
      ST_SQY:  begin mul_a = CmpW'(yd_q);  mul_b = CmpW'(yd_q);  end
      default: begin mul_a = CmpW'(thresh_q); mul_b = CmpW'(thresh_q); end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Distance test on the registered differences.
  assign th_w = CmpW'(thresh_q);
  assign xd_w = CmpW'(xd_q);
  assign yd_w = CmpW'(yd_q);
  always_comb begin
    unique case (method_q)
      METHOD_SQUARE: dist_ok = (xd_w <= th_w) && (yd_w <= th_w);
      METHOD_CIRCLE: dist_ok = (acc_q <= {1'b0, th2_q});
      METHOD_CROSS:  dist_ok = (xd_w <= th_w) || (yd_w <= th_w);
      default:       dist_ok = 1'b0;
    endcase
  end

  // Window length in effect.
  assign window   = (lookback_q > 4'(LOOKBACK_DEPTH)) ? (FillW+1)'(LOOKBACK_DEPTH)
                                                      : (FillW+1)'(lookback_q);
  assign fill_inc = {1'b0, filled_q} + 1'b1;

  // Sequencer and next state of all registers.
  always_comb begin
    state_d    = state_q;
    thresh_d   = thresh_q;
    method_d   = method_q;
    lookback_d = lookback_q;
    tps_d      = tps_q;
    cur_trk_d  = cur_trk_q;
    event_d    = event_q;
    oldest_d   = oldest_q;
    filled_d   = filled_q;
    x_d        = x_q;
    y_d        = y_q;
    cam_d      = cam_q;
    eoe_d      = eoe_q;
    v_d        = v_q;
    i_d        = i_q;
    s_d        = s_q;
    z_d        = z_q;
    cnt_d      = cnt_q;
    xd_d       = xd_q;
    yd_d       = yd_q;
    orig_d     = orig_q;
    th2_d      = th2_q;
    acc_d      = acc_q;
    n_d        = n_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    res_d      = res_q;
    strobe_d   = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    do_eoe     = 1'b0;

    // Configuration writes.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thresh_d   = cfg_data_i;
        CFG_METHOD:    method_d   = cfg_data_i[1:0];
        CFG_LOOKBACK:  lookback_d = cfg_data_i[3:0];
        default:       ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (track_ok) begin
            x_d      = COORD_BITS'(req_i.x_pos);
            y_d      = COORD_BITS'(req_i.y_pos);
            cam_d    = in_cam;
            eoe_d    = req_i.end_of_event;
            v_d      = cur_trk_q[in_cam];
            n_d      = '0;
            pend_v_d = 1'b0;
            state_d  = ST_SETUP;
          end else if (req_i.end_of_event) begin
            do_eoe = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        th2_d   = mul_p;
        i_d     = '0;
        s_d     = oldest_q;
        state_d = ST_SLOT;
      end
      ST_SLOT: begin
        if (i_q == filled_q) begin
          state_d = ST_FINISH;
        end else if (slot_cnt == '0) begin
          i_d = i_q + 1'b1;
          s_d = s_next;
        end else begin
          cnt_d   = slot_cnt;
          z_d     = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        xd_d   = (x_q >= px) ? x_q - px : px - x_q;
        yd_d   = (y_q >= py) ? y_q - py : py - y_q;
        orig_d = (px == '0) && (py == '0);
        state_d = (method_q == METHOD_CIRCLE) ? ST_SQX : ST_TEST;
      end
      ST_SQX: begin
        acc_d   = {1'b0, mul_p};
        state_d = ST_SQY;
      end
      ST_SQY: begin
        acc_d   = acc_q + {1'b0, mul_p};
        state_d = ST_TEST;
      end
      ST_TEST: begin
        // A match sends out the one held before and takes its place.
        if (!orig_q && dist_ok && (n_q < ResCntW'(MAX_RESULTS))) begin
          if (pend_v_q) begin
            res_d             = pend_q;
            res_d.last_result = 1'b0;
            strobe_d          = 1'b1;
          end
          pend_d.match_found   = 1'b1;
          pend_d.this_event    = event_q;
          pend_d.this_track    = 4'(v_q);
          pend_d.matched_event = event_q - 32'(filled_q) + 32'(i_q);
          pend_d.matched_track = 4'(z_q);
          pend_d.last_result   = 1'b0;
          pend_v_d             = 1'b1;
          n_d                  = n_q + 1'b1;
        end
        // Step to the next stored position.
        if (z_q + 1'b1 < cnt_q) begin
          z_d     = z_q + 1'b1;
          state_d = ST_READ;
        end else begin
          i_d     = i_q + 1'b1;
          s_d     = s_next;
          state_d = ST_SLOT;
        end
      end
      ST_FINISH: begin
        if (pend_v_q) begin
          res_d = pend_q;
        end else begin
          res_d.match_found   = 1'b0;
          res_d.this_event    = event_q;
          res_d.this_track    = 4'(v_q);
          res_d.matched_event = '0;
          res_d.matched_track = '0;
        end
        res_d.last_result = 1'b1;
        strobe_d          = 1'b1;
        pend_v_d          = 1'b0;
        wr_en             = 1'b1;
        cur_trk_d[cam_q]  = v_q + 1'b1;
        do_eoe            = eoe_q;
        state_d           = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // End of event: its tracks join the window and the oldest may leave.
    if (do_eoe) begin
      for (int c = 0; c < CAMERAS; c++) begin
        tps_d[PsW'(cur_slot * CAMERAS + c)] = cur_trk_d[c];
        cur_trk_d[c]                        = '0;
      end
      if (fill_inc > window) begin
        oldest_d = (oldest_q == SlotW'(SLOTS - 1)) ? '0 : oldest_q + 1'b1;
      end else begin
        filled_d = FillW'(fill_inc);
      end
      event_d = event_q + 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      thresh_q   <= 16'd160;
      method_q   <= METHOD_SQUARE;
      lookback_q <= 4'd8;
      for (int k = 0; k < SLOTS*CAMERAS; k++) tps_q[k] <= '0;
      for (int c = 0; c < CAMERAS; c++) cur_trk_q[c] <= '0;
      event_q    <= '0;
      oldest_q   <= '0;
      filled_q   <= '0;
      n_q        <= '0;
      pend_v_q   <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      thresh_q   <= thresh_d;
      method_q   <= method_d;
      lookback_q <= lookback_d;
      tps_q      <= tps_d;
      cur_trk_q  <= cur_trk_d;
      event_q    <= event_d;
      oldest_q   <= oldest_d;
      filled_q   <= filled_d;
      n_q        <= n_d;
      pend_v_q   <= pend_v_d;
      strobe_q   <= strobe_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    cam_q  <= cam_d;
    eoe_q  <= eoe_d;
    v_q    <= v_d;
    i_q    <= i_d;
    s_q    <= s_d;
    z_q    <= z_d;
    cnt_q  <= cnt_d;
    xd_q   <= xd_d;
    yd_q   <= yd_d;
    orig_q <= orig_d;
    th2_q  <= th2_d;
    acc_q  <= acc_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  // Position memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;
  assign cfg_ready_o  = 1'b1;

  // The last result of a request leaves the sequencer idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last_result) |-> !busy_o)
    else $error("last result while sequencer still busy");

  // A usable track starts a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && track_ok) |=> busy_o)
    else $error("track request did not start a walk");

  // Results come only out of a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy_o))
    else $error("result strobe without a walk");

  // No more matches than the cap are counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= ResCntW'(MAX_RESULTS))
    else $error("match count above cap");

endmodule
